FILE: design/scc_pkg.sv
// ----------------------------------------------------------------------------
// scc_pkg - shunt current sense and offset calibration, shared definitions
// Widths, result kinds, register indexes and the status bundle of the
// calibration unit.
// ----------------------------------------------------------------------------
package scc_pkg;

  // field widths
  localparam int ADC_W       = 12;
  localparam int CUR_W       = 16;
  localparam int SECTOR_W    = 3;
  localparam int SUM_W       = 19;
  localparam int COUNT_W     = 7;
  localparam int SHUNT_W     = 2;
  localparam int WINDOW_W    = 15;
  localparam int PROD_W      = 2 * CUR_W;
  localparam int KIND_W      = 3;

  // stream word widths (tdata padded to whole bytes)
  localparam int IN_TDATA_W  = 104;
  localparam int IN_TUSER_W  = 1;
  localparam int OUT_TDATA_W = 80;

  // configuration port
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = WINDOW_W;

  localparam logic [CFG_INDEX_W-1:0] REG_SHUNT_COUNT   = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_WINDOW = 1'd1;

  localparam logic [SHUNT_W-1:0]  SHUNT_COUNT_RESET   = 2'd2;
  localparam logic [SHUNT_W-1:0]  SHUNT_THREE         = 2'd3;
  localparam logic [WINDOW_W-1:0] OFFSET_WINDOW_RESET = 15'd2048;

  // nominal converter offset, in 12-bit converter code scaled by 16
  localparam logic [CUR_W-1:0] NOMINAL_OFFSET = 16'd33015;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_CALIBRATING = 3'd0;
  localparam logic [KIND_W-1:0] KIND_CAL_ACCEPT  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_CAL_REJECT  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CURRENTS    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_ALPHA_BETA  = 3'd4;

  typedef struct packed {
    logic             calibrated;
    logic [CUR_W-1:0] offset_u;
    logic [CUR_W-1:0] offset_v;
    logic [CUR_W-1:0] offset_w;
  } cal_status_t;

endpackage

FILE: design/scc_calib.sv
// ----------------------------------------------------------------------------
// scc_calib - shunt offset calibration
// Accumulates 128 sample sets per phase, forms offsets as sum >> 3 and checks
// them against the nominal window. Holds the calibrated flag and offsets.
// ----------------------------------------------------------------------------
module scc_calib (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           step,        // one calibration word commits
  input  logic [scc_pkg::ADC_W-1:0]      adc_u,
  input  logic [scc_pkg::ADC_W-1:0]      adc_v,
  input  logic [scc_pkg::ADC_W-1:0]      adc_w,
  input  logic                           shunt_three,
  input  logic [scc_pkg::WINDOW_W-1:0]   offset_window,
  output scc_pkg::cal_status_t           status,
  output logic [scc_pkg::KIND_W-1:0]     cal_kind
);
  import scc_pkg::*;

  logic               calibrated;
  logic [COUNT_W-1:0] sample_count;
  logic [SUM_W-1:0]   sum_u, sum_v, sum_w;
  logic [CUR_W-1:0]   offset_u, offset_v, offset_w;

  logic [SUM_W-1:0]   sum_u_next, sum_v_next, sum_w_next;
  logic [CUR_W-1:0]   new_u, new_v, new_w;
  logic [CUR_W:0]     win_lo, win_hi;
  logic               last, pass;

  function automatic logic in_window(input logic [CUR_W-1:0] off,
                                     input logic [CUR_W:0]   lo,
                                     input logic [CUR_W:0]   hi);
    logic [CUR_W:0] x;
    x = {1'b0, off};
    return (x > lo) && (x < hi);
  endfunction

  always_comb begin
    sum_u_next = sum_u + SUM_W'(adc_u);
    sum_v_next = sum_v + SUM_W'(adc_v);
    sum_w_next = sum_w + SUM_W'(adc_w);
    last       = &sample_count;
    new_u      = sum_u_next[SUM_W-1:3];
    new_v      = sum_v_next[SUM_W-1:3];
    new_w      = shunt_three ? sum_w_next[SUM_W-1:3] : NOMINAL_OFFSET;
    // upper bound kept at 17 bits: no wrap for wide windows
    win_lo     = {1'b0, NOMINAL_OFFSET} - (CUR_W+1)'(offset_window);
    win_hi     = {1'b0, NOMINAL_OFFSET} + (CUR_W+1)'(offset_window);
    pass       = in_window(new_u, win_lo, win_hi) && in_window(new_v, win_lo, win_hi)
                 && in_window(new_w, win_lo, win_hi);
    if (!last) begin
      cal_kind = KIND_CALIBRATING;
    end else if (pass) begin
      cal_kind = KIND_CAL_ACCEPT;
    end else begin
      cal_kind = KIND_CAL_REJECT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      calibrated   <= 1'b0;
      sample_count <= '0;
      sum_u        <= '0;
      sum_v        <= '0;
      sum_w        <= '0;
      offset_u     <= '0;
      offset_v     <= '0;
      offset_w     <= '0;
    end else if (step) begin
      sample_count <= sample_count + COUNT_W'(1);
      if (last) begin
        sum_u <= '0;
        sum_v <= '0;
        sum_w <= '0;
        if (pass) begin
          calibrated <= 1'b1;
          offset_u   <= new_u;
          offset_v   <= new_v;
          offset_w   <= new_w;
        end else begin
          offset_u <= '0;
          offset_v <= '0;
          offset_w <= '0;
        end
      end else begin
        sum_u <= sum_u_next;
        sum_v <= sum_v_next;
        sum_w <= sum_w_next;
      end
    end
  end

  assign status.calibrated = calibrated;
  assign status.offset_u   = offset_u;
  assign status.offset_v   = offset_v;
  assign status.offset_w   = offset_w;

endmodule

FILE: design/shunt_current_sense_calibrate_top.sv
// ----------------------------------------------------------------------------
// shunt_current_sense_calibrate_top - shunt current reconstruction
// Offset calibration of three shunt channels, then phase currents from the
// shunt samples or inverse Park alpha/beta from the previous dq currents.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake            payload
//  -------   ---  -------------------  ------------------------------------
//  s_*       in   s_tvalid / s_tready  tdata: adc_u adc_v adc_w sector
//                                      id_prev iq_prev sin_val cos_val
//                                      tuser: sampling
//  m_*       out  m_tvalid / m_tready  tdata: i_u i_v i_w i_alpha i_beta
//                                      tuser: kind
//  cfg_*     in   cfg_we               0 shunt_count, 1 offset_window
//
//  One word per cycle sustained while m_tready is high; an accepted word
//  fills the input register, then the output register, which raises m_tvalid.
//  Between the two registers: calibration adds and window compare, phase
//  subtractions, and the four 16x16 Park products with their sum and shift.
//  The output register loads when empty or when m_tready takes its word, so
//  input is taken while a finished word waits; s_tready drops only when both
//  registers are full and m_tready is low.
//  rst is synchronous: calibration restarts, both registers drain, registers
//  return to shunt_count = 2 and offset_window = 2048.
//
module shunt_current_sense_calibrate_top (
  input  logic                              clk,
  input  logic                              rst,
  // fields, low bit up: adc_u[11:0] adc_v[23:12] adc_w[35:24] sector[38:36]
  // id_prev[54:39] iq_prev[70:55] sin_val[86:71] cos_val[102:87] pad[103]
  input  logic [scc_pkg::IN_TDATA_W-1:0]    s_tdata,
  input  logic [scc_pkg::IN_TUSER_W-1:0]    s_tuser,     // sampling[0]
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // fields, low bit up: i_u[15:0] i_v[31:16] i_w[47:32] i_alpha[63:48]
  // i_beta[79:64]
  output logic [scc_pkg::OUT_TDATA_W-1:0]   m_tdata,
  output logic [scc_pkg::KIND_W-1:0]        m_tuser,     // kind[2:0]
  output logic                              m_tvalid,
  input  logic                              m_tready,
  input  logic                              cfg_we,
  input  logic [scc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [scc_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import scc_pkg::*;

  // configuration registers
  logic [SHUNT_W-1:0]  shunt_count;
  logic [WINDOW_W-1:0] offset_window;

  always_ff @(posedge clk) begin
    if (rst) begin
      shunt_count   <= SHUNT_COUNT_RESET;
      offset_window <= OFFSET_WINDOW_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SHUNT_COUNT:   shunt_count   <= cfg_data[SHUNT_W-1:0];
        REG_OFFSET_WINDOW: offset_window <= cfg_data;
        default: ;
      endcase
    end
  end

  // register handshake: each register loads when empty or when it moves on
  logic v1;
  logic load_out, move_out;

  assign load_out = !m_tvalid || m_tready;
  assign s_tready = !v1 || load_out;
  assign move_out = v1 && load_out;

  // input register
  logic [ADC_W-1:0]    adc_u1, adc_v1, adc_w1;
  logic                sampling1;
  logic [SECTOR_W-1:0] sector1;
  logic signed [CUR_W-1:0] id1, iq1, sin1, cos1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (s_tready) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      adc_u1    <= s_tdata[11:0];
      adc_v1    <= s_tdata[23:12];
      adc_w1    <= s_tdata[35:24];
      sector1   <= s_tdata[38:36];
      id1       <= s_tdata[54:39];
      iq1       <= s_tdata[70:55];
      sin1      <= s_tdata[86:71];
      cos1      <= s_tdata[102:87];
      sampling1 <= s_tuser[0];
    end
  end

  // calibration unit; its state commits as the word enters the output register
  cal_status_t       status;
  logic [KIND_W-1:0] cal_kind;
  logic              shunt_three;

  assign shunt_three = (shunt_count == SHUNT_THREE);

  scc_calib u_calib (
    .clk           (clk),
    .rst           (rst),
    .step          (move_out && !status.calibrated),
    .adc_u         (adc_u1),
    .adc_v         (adc_v1),
    .adc_w         (adc_w1),
    .shunt_three   (shunt_three),
    .offset_window (offset_window),
    .status        (status),
    .cal_kind      (cal_kind)
  );

  // phase currents; converter code scaled by 16 to match the offsets
  logic [CUR_W-1:0] raw_u, raw_v, raw_w;
  logic [CUR_W-1:0] t_u, t_v, t_w;     // three-shunt per phase
  logic [CUR_W-1:0] d_u, d_v;          // two-shunt per phase
  logic [CUR_W-1:0] cur_u, cur_v, cur_w;
  logic [KIND_W-1:0] kind1;
  logic signed [PROD_W-1:0] p_idc, p_iqs, p_ids, p_iqc;
  logic signed [PROD_W:0]   sum_alpha, sum_beta;
  logic [CUR_W-1:0]         o_u, o_v, o_w, o_alpha, o_beta;

  always_comb begin
    raw_u = {adc_u1, 4'b0000};
    raw_v = {adc_v1, 4'b0000};
    raw_w = {adc_w1, 4'b0000};
    t_u   = status.offset_u - raw_u;
    t_v   = status.offset_v - raw_v;
    t_w   = status.offset_w - raw_w;
    d_u   = raw_u - status.offset_u;
    d_v   = raw_v - status.offset_v;

    if (shunt_three) begin
      cur_u = t_u;
      cur_v = t_v;
      cur_w = t_w;
      // rebuild the phase whose shunt window is too short in this sector
      case (sector1) inside
        3'd2, 3'd3: cur_u = -t_v - t_w;
        3'd1, 3'd5: cur_v = -t_u - t_w;
        default: ;
      endcase
    end else begin
      cur_u = d_u;
      cur_v = d_v;
      cur_w = -d_u - d_v;
    end

    if (!status.calibrated) begin
      kind1 = cal_kind;
    end else if (sampling1) begin
      kind1 = KIND_CURRENTS;
    end else begin
      kind1 = KIND_ALPHA_BETA;
    end

    // inverse Park: exact sum, floor shift by 15, wrap to 16 bits
    p_idc     = id1 * cos1;
    p_iqs     = iq1 * sin1;
    p_ids     = id1 * sin1;
    p_iqc     = iq1 * cos1;
    sum_alpha = {p_idc[PROD_W-1], p_idc} - {p_iqs[PROD_W-1], p_iqs};
    sum_beta  = {p_ids[PROD_W-1], p_ids} + {p_iqc[PROD_W-1], p_iqc};

    // fields outside the word's kind read as zero
    o_u     = '0;
    o_v     = '0;
    o_w     = '0;
    o_alpha = '0;
    o_beta  = '0;
    if (kind1 == KIND_CURRENTS) begin
      o_u = cur_u;
      o_v = cur_v;
      o_w = cur_w;
    end
    if (kind1 == KIND_ALPHA_BETA) begin
      o_alpha = sum_alpha[CUR_W+14:15];
      o_beta  = sum_beta[CUR_W+14:15];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (move_out) begin
      m_tdata <= {o_beta, o_alpha, o_w, o_v, o_u};
      m_tuser <= kind1;
    end
  end

endmodule

FILE: design/scc_checker.sv
// ----------------------------------------------------------------------------
// scc_checker - port checks for the shunt current sense block
// Watches reset, output stall behavior, unused result fields and the input
// back-pressure condition.
// ----------------------------------------------------------------------------
module scc_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tready,
  input logic [scc_pkg::OUT_TDATA_W-1:0]   m_tdata,
  input logic [scc_pkg::KIND_W-1:0]        m_tuser,
  input logic                              m_tvalid,
  input logic                              m_tready
);
  import scc_pkg::*;

  // reset drains the output
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output word valid after reset");

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
      m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled output word changed");

  // currents are zero unless the word carries currents
  a_cur_zero: assert property (@(posedge clk) disable iff (rst)
      m_tvalid && (m_tuser != KIND_CURRENTS) |-> (m_tdata[47:0] == '0))
    else $error("phase current fields set for a non-current word");

  // alpha/beta are zero unless the word carries them
  a_ab_zero: assert property (@(posedge clk) disable iff (rst)
      m_tvalid && (m_tuser != KIND_ALPHA_BETA) |-> (m_tdata[79:48] == '0))
    else $error("alpha/beta fields set for a non-alpha/beta word");

  // input back-pressure only with a blocked output
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
      !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled while output is free");

endmodule

bind shunt_current_sense_calibrate_top scc_checker u_scc_checker (
  .clk       (clk),
  .rst       (rst),
  .s_tready  (s_tready),
  .m_tdata   (m_tdata),
  .m_tuser   (m_tuser),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready)
);

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top - shunt current sense and offset calibration testbench
// Walks the block through rejected and accepted offset calibrations, then
// phase current and alpha/beta words under random pacing on both streams.
// A local predictor computes every result word, and a checker compares each
// result word with it field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import scc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int CAL_WORDS   = 128;
  localparam int ADC_MAX     = 4095;

  // one input word, fields as the block sees them
  typedef struct packed {
    logic [ADC_W-1:0]        adc_u;
    logic [ADC_W-1:0]        adc_v;
    logic [ADC_W-1:0]        adc_w;
    logic                    sampling;
    logic [SECTOR_W-1:0]     sector;
    logic signed [CUR_W-1:0] id_prev;
    logic signed [CUR_W-1:0] iq_prev;
    logic signed [CUR_W-1:0] sin_val;
    logic signed [CUR_W-1:0] cos_val;
  } shunt_word_t;

  // one result word
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CUR_W-1:0]  i_u;
    logic [CUR_W-1:0]  i_v;
    logic [CUR_W-1:0]  i_w;
    logic [CUR_W-1:0]  i_alpha;
    logic [CUR_W-1:0]  i_beta;
  } phase_result_t;

  logic                   clk;
  logic                   rst;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic [IN_TUSER_W-1:0]  s_tuser;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [KIND_W-1:0]      m_tuser;
  logic                   m_tvalid;
  logic                   m_tready;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  shunt_current_sense_calibrate_top uut (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Predictor state: registers and calibration state as the block holds them
  // --------------------------------------------------------------------------
  logic [SHUNT_W-1:0]  model_shunts = SHUNT_COUNT_RESET;
  logic [WINDOW_W-1:0] model_window = OFFSET_WINDOW_RESET;
  logic                cal_done     = 1'b0;
  logic [COUNT_W-1:0]  cal_count    = '0;
  logic [SUM_W-1:0]    acc_u = '0, acc_v = '0, acc_w = '0;
  logic [CUR_W-1:0]    off_u = '0, off_v = '0, off_w = '0;

  phase_result_t pending_phase_results [$];
  phase_result_t head;
  int            error_count = 0;
  int            cycle_count = 0;
  int            send_burst_left = 0;

  // calibration sample sets, built so each phase sum lands on a chosen offset
  logic [ADC_W-1:0] cal_u [CAL_WORDS];
  logic [ADC_W-1:0] cal_v [CAL_WORDS];
  logic [ADC_W-1:0] cal_w [CAL_WORDS];

  // strictly inside nominal +/- window; upper bound is not wrapped, so a wide
  // window leaves no upper limit at all
  function automatic bit near_nominal(input logic [CUR_W-1:0] offset);
    int o;
    int nominal;
    int lo_bound;
    int hi_bound;
    o        = int'(offset);
    nominal  = int'(NOMINAL_OFFSET);
    lo_bound = nominal - int'(model_window);
    hi_bound = nominal + int'(model_window);
    return (o > lo_bound) && (o < hi_bound);
  endfunction

  // result of one accepted word; advances the predictor state
  function automatic phase_result_t predict_sense(input shunt_word_t w);
    phase_result_t r;
    logic [CUR_W-1:0] cu, cv, cw;
    longint pa, pb;
    r = '0;
    if (!cal_done) begin
      // sampling flag does not matter here: every word is summed
      acc_u     = acc_u + SUM_W'(w.adc_u);
      acc_v     = acc_v + SUM_W'(w.adc_v);
      acc_w     = acc_w + SUM_W'(w.adc_w);
      cal_count = cal_count + COUNT_W'(1);
      r.kind    = KIND_CALIBRATING;
      if (cal_count == '0) begin
        // 128th word: offsets are sum / 8
        off_u = acc_u[SUM_W-1:3];
        off_v = acc_v[SUM_W-1:3];
        off_w = acc_w[SUM_W-1:3];
        acc_u = '0;
        acc_v = '0;
        acc_w = '0;
        if (model_shunts != SHUNT_THREE) off_w = NOMINAL_OFFSET;
        if (near_nominal(off_u) && near_nominal(off_v) && near_nominal(off_w)) begin
          cal_done = 1'b1;
          r.kind   = KIND_CAL_ACCEPT;
        end else begin
          off_u  = '0;
          off_v  = '0;
          off_w  = '0;
          r.kind = KIND_CAL_REJECT;
        end
      end
    end else if (w.sampling) begin
      if (model_shunts == SHUNT_THREE) begin
        cu = off_u - {w.adc_u, 4'b0000};
        cv = off_v - {w.adc_v, 4'b0000};
        cw = off_w - {w.adc_w, 4'b0000};
        // rebuild the phase that is not trusted in this sector
        if (w.sector == 3'd2 || w.sector == 3'd3) cu = -cv - cw;
        if (w.sector == 3'd1 || w.sector == 3'd5) cv = -cu - cw;
      end else begin
        // shunt counts 0 and 1 fall in here too
        cu = {w.adc_u, 4'b0000} - off_u;
        cv = {w.adc_v, 4'b0000} - off_v;
        cw = -cu - cv;
      end
      r.kind = KIND_CURRENTS;
      r.i_u  = cu;
      r.i_v  = cv;
      r.i_w  = cw;
    end else begin
      // inverse Park, exact products, floor shift, wrap to 16 bits
      pa = longint'($signed(w.id_prev)) * longint'($signed(w.cos_val))
         - longint'($signed(w.iq_prev)) * longint'($signed(w.sin_val));
      pb = longint'($signed(w.id_prev)) * longint'($signed(w.sin_val))
         + longint'($signed(w.iq_prev)) * longint'($signed(w.cos_val));
      pa = pa >>> 15;
      pb = pb >>> 15;
      r.kind    = KIND_ALPHA_BETA;
      r.i_alpha = pa[CUR_W-1:0];
      r.i_beta  = pb[CUR_W-1:0];
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Random field values, extremes favored
  // --------------------------------------------------------------------------
  function automatic logic [CUR_W-1:0] rand_q15();
    logic [31:0] t;
    t = $urandom;
    case ($urandom_range(0, 15))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'hffff;
      3:       return 16'h0000;
      default: return t[CUR_W-1:0];
    endcase
  endfunction

  function automatic logic [ADC_W-1:0] rand_adc();
    logic [31:0] t;
    t = $urandom;
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return '1;
      default: return t[ADC_W-1:0];
    endcase
  endfunction

  function automatic shunt_word_t random_word();
    shunt_word_t w;
    w.adc_u    = rand_adc();
    w.adc_v    = rand_adc();
    w.adc_w    = rand_adc();
    w.sampling = 1'($urandom_range(0, 1));
    w.sector   = SECTOR_W'($urandom_range(0, 7));
    w.id_prev  = rand_q15();
    w.iq_prev  = rand_q15();
    w.sin_val  = rand_q15();
    w.cos_val  = rand_q15();
    return w;
  endfunction

  function automatic shunt_word_t make_word(
    input logic [ADC_W-1:0] au, input logic [ADC_W-1:0] av, input logic [ADC_W-1:0] aw,
    input logic smp, input logic [SECTOR_W-1:0] sec,
    input logic [CUR_W-1:0] id, input logic [CUR_W-1:0] iq,
    input logic [CUR_W-1:0] sn, input logic [CUR_W-1:0] cs);
    shunt_word_t w;
    w.adc_u    = au;
    w.adc_v    = av;
    w.adc_w    = aw;
    w.sampling = smp;
    w.sector   = sec;
    w.id_prev  = id;
    w.iq_prev  = iq;
    w.sin_val  = sn;
    w.cos_val  = cs;
    return w;
  endfunction

  // sender gap: mostly none or short, a few long, now and then a gapless run
  function automatic int pick_gap();
    int r;
    if (send_burst_left > 0) begin
      send_burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 6) begin
      send_burst_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // sum of 128 samples that gives offset target (sum >> 3 == target)
  function automatic int total_for(input int target);
    int s;
    s = 8 * target + int'($urandom_range(0, 7));
    if (s > CAL_WORDS * ADC_MAX) s = CAL_WORDS * ADC_MAX;
    return s;
  endfunction

  // next sample of a set: near the mean, but the rest must stay reachable
  function automatic int next_sample(input int remaining, input int count);
    int lo_v;
    int hi_v;
    int v;
    lo_v = remaining - ADC_MAX * (count - 1);
    if (lo_v < 0) lo_v = 0;
    hi_v = (remaining > ADC_MAX) ? ADC_MAX : remaining;
    v = remaining / count + int'($urandom_range(0, 80)) - 40;
    if (v < lo_v) v = lo_v;
    if (v > hi_v) v = hi_v;
    return v;
  endfunction

  // --------------------------------------------------------------------------
  // Bus tasks
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string field, input logic [CUR_W-1:0] got,
                                 input logic [CUR_W-1:0] want);
    $display("MISMATCH %s: got %h expected %h at %0t", field, got, want, $realtime);
    error_count++;
  endtask

  // present one word at a falling edge, hold it until taken
  task automatic send_word(input shunt_word_t w);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tdata  <= {1'b0, w.cos_val, w.sin_val, w.iq_prev, w.id_prev, w.sector,
                 w.adc_w, w.adc_v, w.adc_u};
    s_tuser  <= w.sampling;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_phase_results.push_back(predict_sense(w));
  endtask

  // stop sending and let every pending result word come out
  task automatic wait_idle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_phase_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // register write; only called with the block idle
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (idx == REG_SHUNT_COUNT) model_shunts = value[SHUNT_W-1:0];
    else                        model_window = value;
  endtask

  task automatic build_cal_set(input int tu, input int tv, input int tw);
    int ru, rv, rw;
    ru = total_for(tu);
    rv = total_for(tv);
    rw = total_for(tw);
    for (int k = 0; k < CAL_WORDS; k++) begin
      cal_u[k] = ADC_W'(next_sample(ru, CAL_WORDS - k));
      cal_v[k] = ADC_W'(next_sample(rv, CAL_WORDS - k));
      cal_w[k] = ADC_W'(next_sample(rw, CAL_WORDS - k));
      ru -= int'(cal_u[k]);
      rv -= int'(cal_v[k]);
      rw -= int'(cal_w[k]);
    end
  endtask

  // calibration words carry the built samples; other fields are noise
  task automatic send_cal_range(input int first, input int last);
    shunt_word_t w;
    for (int k = first; k <= last; k++) begin
      w       = random_word();
      w.adc_u = cal_u[k];
      w.adc_v = cal_v[k];
      w.adc_w = cal_w[k];
      send_word(w);
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests. Calibration can be accepted only once per run (no second reset),
  // so every reject case comes first.
  // --------------------------------------------------------------------------

  // reset registers (two shunts, window 2048); U sits exactly on the lower
  // bound, which is outside since the window is open
  task automatic test_reject_at_reset_values();
    build_cal_set(30967, 35062, 33015);
    send_cal_range(0, CAL_WORDS - 1);
    wait_idle();
  endtask

  // three shunts: W offset counts and sits exactly on the upper bound
  task automatic test_reject_upper_bound();
    write_reg(REG_SHUNT_COUNT, CFG_DATA_W'(SHUNT_THREE));
    write_reg(REG_OFFSET_WINDOW, OFFSET_WINDOW_RESET);
    build_cal_set(30968, 35062, 35063);
    send_cal_range(0, CAL_WORDS - 1);
    wait_idle();
  endtask

  // full window (no upper limit); W samples are far off, but the shunt count
  // drops to two halfway, and the value at the last word decides: W is forced
  // to nominal and the set is accepted
  task automatic test_accept_with_midway_switch();
    write_reg(REG_OFFSET_WINDOW, '1);
    write_reg(REG_SHUNT_COUNT, CFG_DATA_W'(SHUNT_THREE));
    build_cal_set(65520, 249, 0);
    send_cal_range(0, CAL_WORDS / 2 - 1);
    wait_idle();
    write_reg(REG_SHUNT_COUNT, CFG_DATA_W'(SHUNT_COUNT_RESET));
    send_cal_range(CAL_WORDS / 2, CAL_WORDS - 1);
    wait_idle();
  endtask

  // every sector under three shunts, then shunt counts 0, 1 and 2
  task automatic test_phase_currents();
    shunt_word_t w;
    write_reg(REG_SHUNT_COUNT, CFG_DATA_W'(SHUNT_THREE));
    for (int s = 0; s < 8; s++) begin
      w          = random_word();
      w.sampling = 1'b1;
      w.sector   = s[SECTOR_W-1:0];
      send_word(w);
    end
    send_word(make_word('0, '0, '0, 1'b1, 3'd1, '0, '0, '0, '0));
    send_word(make_word('1, '1, '1, 1'b1, 3'd2, '0, '0, '0, '0));
    wait_idle();
    write_reg(REG_SHUNT_COUNT, CFG_DATA_W'(0));
    send_word(make_word('0, '0, '0, 1'b1, 3'd3, '0, '0, '0, '0));
    send_word(make_word('1, '1, '1, 1'b1, 3'd5, '0, '0, '0, '0));
    wait_idle();
    write_reg(REG_SHUNT_COUNT, CFG_DATA_W'(1));
    send_word(make_word('1, '0, '1, 1'b1, 3'd1, '0, '0, '0, '0));
    wait_idle();
    write_reg(REG_SHUNT_COUNT, CFG_DATA_W'(SHUNT_COUNT_RESET));
    send_word(make_word('0, '1, '0, 1'b1, 3'd2, '0, '0, '0, '0));
    send_word(make_word('1, '1, '1, 1'b1, 3'd6, '0, '0, '0, '0));
    wait_idle();
  endtask

  // inverse Park corners: most negative products, wraps, floor of -1
  task automatic test_alpha_beta();
    shunt_word_t w;
    send_word(make_word('0, '0, '0, 1'b0, '0, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
    send_word(make_word('1, '1, '1, 1'b0, '1, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff));
    send_word(make_word('0, '0, '0, 1'b0, '0, 16'h8000, 16'h7fff, 16'h8000, 16'h8000));
    send_word(make_word('0, '0, '0, 1'b0, '0, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000));
    send_word(make_word('0, '0, '0, 1'b0, '0, 16'hffff, 16'h0000, 16'h0000, 16'h0001));
    send_word(make_word('0, '0, '0, 1'b0, '0, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_word(make_word('0, '0, '0, 1'b0, '0, 16'h0001, 16'hffff, 16'h7fff, 16'h7fff));
    w          = random_word();
    w.sampling = 1'b0;
    send_word(w);
    wait_idle();
  endtask

  // mixed current and alpha/beta words over several register settings
  task automatic test_random_traffic();
    logic [SHUNT_W-1:0] shunts;
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        1:       shunts = SHUNT_COUNT_RESET;
        2:       shunts = 2'd0;
        3:       shunts = 2'd1;
        default: shunts = SHUNT_THREE;
      endcase
      write_reg(REG_SHUNT_COUNT, CFG_DATA_W'(shunts));
      write_reg(REG_OFFSET_WINDOW, CFG_DATA_W'($urandom_range(0, 32767)));
      for (int k = 0; k < 30; k++) send_word(random_word());
      wait_idle();
    end
  endtask

  // --------------------------------------------------------------------------
  // Clock, pacing, checking, watchdog
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: short stalls mostly, a few long ones, and stall-free runs
  initial begin : sink_pacing
    int stall;
    m_tready = 1'b0;
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 4) == 0) begin
        m_tready <= 1'b1;
        repeat ($urandom_range(20, 60)) @(negedge clk);
      end else begin
        stall = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 3);
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 4)) @(negedge clk);
      end
    end
  end

  // every taken result word against the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_phase_results.size() == 0) begin
        report_mismatch("word with nothing pending", m_tdata[15:0], '0);
      end else begin
        head = pending_phase_results.pop_front();
        if (m_tuser !== head.kind)
          report_mismatch("kind", CUR_W'(m_tuser), CUR_W'(head.kind));
        if (m_tdata[15:0] !== head.i_u)     report_mismatch("i_u", m_tdata[15:0], head.i_u);
        if (m_tdata[31:16] !== head.i_v)    report_mismatch("i_v", m_tdata[31:16], head.i_v);
        if (m_tdata[47:32] !== head.i_w)    report_mismatch("i_w", m_tdata[47:32], head.i_w);
        if (m_tdata[63:48] !== head.i_alpha)
          report_mismatch("i_alpha", m_tdata[63:48], head.i_alpha);
        if (m_tdata[79:64] !== head.i_beta)
          report_mismatch("i_beta", m_tdata[79:64], head.i_beta);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("shunt_current_sense_calibrate_top verification failed");
      $finish;
    end
  end

  initial begin
    rst       = 1'b1;
    s_tdata   = '0;
    s_tuser   = '0;
    s_tvalid  = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reject_at_reset_values();
    test_reject_upper_bound();
    test_accept_with_midway_switch();
    test_phase_currents();
    test_alpha_beta();
    test_random_traffic();

    // wait_idle above already drained the pipe and covered its latency
    if (error_count == 0) begin
      $display("shunt_current_sense_calibrate_top verification clean");
    end else begin
      $display("shunt_current_sense_calibrate_top verification failed");
    end
    $finish;
  end

endmodule
